@@ src/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// shared widths, reset values and defaults for the tournament selector
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int TOURNAMENT_SIZE_DEF = 4;
   localparam int POP_INDEX_BITS_DEF  = 8;

   localparam int ENERGY_W  = 16;
   localparam int DRAW_W    = 14;
   localparam int RATE_W    = 16;
   localparam int FRAC_BITS = 16;
   localparam int KEEP_W    = RATE_W + 1;
   localparam int SCALED_W  = DRAW_W + FRAC_BITS;

   localparam logic [RATE_W-1:0]   WIN_RATE_RESET = 16'd52429;
   localparam logic [KEEP_W-1:0]   Q16_ONE        = 17'h10000;
   localparam logic [SCALED_W-1:0] DRAW_SCALE     = 30'd10000;

   localparam int QUEUE_DEPTH = 2;

endpackage

@@ src/probabilistic_tournament_select.sv @@
// ----------------------------------------------------------------------------
// probabilistic_tournament_select
// one probabilistic tournament per request, ranked by energy
// ----------------------------------------------------------------------------
// usage
//   req channel carries one tournament: candidate indices, energies, draws
//   rsp channel returns the winner: index, energy and ascending rank
//   csr_wr_en / csr_wr_data write the win rate p in Q0.16
// timing
//   a request is registered in the queue, then in the response register once it is free
//   one request per cycle sustained while thresholds are settled and the receiver
//   is ready; ranking and try compare sit in front of a two-entry queue, the
//   winner mux sits behind it in the response register; after reset and after
//   every csr write, req_tready stays low while the threshold multiplier chain settles
// stalls
//   a stalled response holds; the queue keeps taking requests until full,
//   then req_tready drops
// ----------------------------------------------------------------------------
module probabilistic_tournament_select #(
   parameter int TOURNAMENT_SIZE = pts_pkg::TOURNAMENT_SIZE_DEF,
   parameter int POP_INDEX_BITS  = pts_pkg::POP_INDEX_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // cand_index_0..N-1, cand_energy_0..N-1, draw_0..N-2, zero pad
   input  logic [((TOURNAMENT_SIZE*(POP_INDEX_BITS + pts_pkg::ENERGY_W)
                 + (TOURNAMENT_SIZE-1)*pts_pkg::DRAW_W + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // winner_index, winner_energy, winner_rank, zero pad
   output logic [((POP_INDEX_BITS + pts_pkg::ENERGY_W + $clog2(TOURNAMENT_SIZE) + 7) / 8)
                 * 8 - 1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_wr_en,
   input  logic [pts_pkg::RATE_W-1:0] csr_wr_data
);
   import pts_pkg::*;

   localparam int N        = TOURNAMENT_SIZE;
   localparam int RW       = $clog2(N);
   localparam int REQ_BITS = N * (POP_INDEX_BITS + ENERGY_W) + (N - 1) * DRAW_W;
   localparam int ENTRY_W  = N * (POP_INDEX_BITS + ENERGY_W + RW) + RW;

   logic [(N-1)*SCALED_W-1:0] scale;
   logic                      settled;
   logic [ENTRY_W-1:0]        entry;
   logic                      q_in_ready;
   logic                      q_out_valid;
   logic                      q_out_ready;
   logic [ENTRY_W-1:0]        q_out_data;

   pts_thresh #(
      .TOURNAMENT_SIZE(TOURNAMENT_SIZE)
   ) u_thresh (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .scale      (scale),
      .settled    (settled)
   );

   pts_front #(
      .TOURNAMENT_SIZE(TOURNAMENT_SIZE),
      .POP_INDEX_BITS (POP_INDEX_BITS)
   ) u_front (
      .req_data(req_tdata[REQ_BITS-1:0]),
      .scale   (scale),
      .entry   (entry)
   );

   assign req_tready = settled && q_in_ready;

   pts_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid && settled),
      .in_ready (q_in_ready),
      .in_data  (entry),
      .out_valid(q_out_valid),
      .out_ready(q_out_ready),
      .out_data (q_out_data)
   );

   pts_back #(
      .TOURNAMENT_SIZE(TOURNAMENT_SIZE),
      .POP_INDEX_BITS (POP_INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_out_valid),
      .in_ready  (q_out_ready),
      .in_data   (q_out_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ src/pts_thresh.sv @@
// ----------------------------------------------------------------------------
// pts_thresh
// win rate register and per-try scaled thresholds, p*(1-p)^c times 10000
// ----------------------------------------------------------------------------
module pts_thresh #(
   parameter int TOURNAMENT_SIZE = pts_pkg::TOURNAMENT_SIZE_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   csr_wr_en,
   input  logic [pts_pkg::RATE_W-1:0]                             csr_wr_data,
   output logic [(TOURNAMENT_SIZE-1)*pts_pkg::SCALED_W-1:0]       scale,
   output logic                                                   settled
);
   import pts_pkg::*;

   localparam int NUM_DRAWS = TOURNAMENT_SIZE - 1;
   localparam int SETTLE_W  = $clog2(TOURNAMENT_SIZE + 1);

   logic [RATE_W-1:0]   win_rate_ff;
   logic [KEEP_W-1:0]   keep;
   logic [RATE_W-1:0]   thr [NUM_DRAWS];
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_rate_ff <= WIN_RATE_RESET;
      end else if (csr_wr_en) begin
         win_rate_ff <= csr_wr_data;
      end
   end

   assign keep = Q16_ONE - {1'b0, win_rate_ff};

   // thresholds ripple through the per-try step registers after a write
   always_comb begin
      settle_in = settle_ff;
      if (csr_wr_en) begin
         settle_in = SETTLE_W'(TOURNAMENT_SIZE);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_W'(TOURNAMENT_SIZE);
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign settled = (settle_ff == '0);

   for (genvar c = 0; c < NUM_DRAWS; c++) begin : g_try
      logic [SCALED_W-1:0] scale_ff, scale_in;

      if (c == 0) begin : g_first
         assign thr[c] = win_rate_ff;
      end else begin : g_next
         logic [RATE_W+KEEP_W-1:0] prod;
         logic [RATE_W-1:0]        step_ff, step_in;

         assign prod    = thr[c-1] * keep;
         assign step_in = prod[FRAC_BITS +: RATE_W];

         always_ff @(posedge clock) begin
            step_ff <= step_in;
         end

         assign thr[c] = step_ff;
      end

      assign scale_in = SCALED_W'(thr[c]) * DRAW_SCALE;

      always_ff @(posedge clock) begin
         scale_ff <= scale_in;
      end

      assign scale[c*SCALED_W +: SCALED_W] = scale_ff;
   end

endmodule

@@ src/pts_front.sv @@
// ----------------------------------------------------------------------------
// pts_front
// ranks the candidates by energy and resolves which try wins
// ----------------------------------------------------------------------------
module pts_front #(
   parameter int TOURNAMENT_SIZE = pts_pkg::TOURNAMENT_SIZE_DEF,
   parameter int POP_INDEX_BITS  = pts_pkg::POP_INDEX_BITS_DEF
) (
   input  logic [TOURNAMENT_SIZE*POP_INDEX_BITS + TOURNAMENT_SIZE*pts_pkg::ENERGY_W
                 + (TOURNAMENT_SIZE-1)*pts_pkg::DRAW_W - 1:0]       req_data,
   input  logic [(TOURNAMENT_SIZE-1)*pts_pkg::SCALED_W-1:0]         scale,
   output logic [TOURNAMENT_SIZE*(POP_INDEX_BITS + pts_pkg::ENERGY_W
                 + $clog2(TOURNAMENT_SIZE)) + $clog2(TOURNAMENT_SIZE) - 1:0] entry
);
   import pts_pkg::*;

   localparam int N         = TOURNAMENT_SIZE;
   localparam int PB        = POP_INDEX_BITS;
   localparam int RW        = $clog2(N);
   localparam int NUM_DRAWS = N - 1;
   localparam int ENG_OFF   = N * PB;
   localparam int DRAW_OFF  = ENG_OFF + N * ENERGY_W;
   localparam int RANK_OFF  = N * (PB + ENERGY_W);
   localparam int WIN_OFF   = RANK_OFF + N * RW;

   logic signed [ENERGY_W-1:0] eng  [N];
   logic [RW-1:0]              rank [N];
   logic [NUM_DRAWS-1:0]       pass;
   logic [RW-1:0]              win_rank;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         eng[i] = $signed(req_data[ENG_OFF + i*ENERGY_W +: ENERGY_W]);
      end
   end

   // stable ascending rank: lower slot wins ties
   always_comb begin
      for (int i = 0; i < N; i++) begin
         rank[i] = '0;
         for (int j = 0; j < N; j++) begin
            if ((eng[j] < eng[i]) || ((eng[j] == eng[i]) && (j < i))) begin
               rank[i] = rank[i] + RW'(1);
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_DRAWS; c++) begin
         pass[c] = {req_data[DRAW_OFF + c*DRAW_W +: DRAW_W], {FRAC_BITS{1'b0}}}
                   < scale[c*SCALED_W +: SCALED_W];
      end
   end

   // earliest successful try takes priority
   always_comb begin
      win_rank = '0;
      for (int c = NUM_DRAWS - 1; c >= 0; c--) begin
         if (pass[c]) begin
            win_rank = RW'(N - 1 - c);
         end
      end
   end

   always_comb begin
      entry = '0;
      entry[0 +: RANK_OFF] = req_data[0 +: RANK_OFF];
      for (int i = 0; i < N; i++) begin
         entry[RANK_OFF + i*RW +: RW] = rank[i];
      end
      entry[WIN_OFF +: RW] = win_rank;
   end

endmodule

@@ src/pts_queue.sv @@
// ----------------------------------------------------------------------------
// pts_queue
// short request queue between the ranking front and the select back
// ----------------------------------------------------------------------------
module pts_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pts_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ src/pts_back.sv @@
// ----------------------------------------------------------------------------
// pts_back
// picks the candidate holding the winning rank into the response register
// ----------------------------------------------------------------------------
module pts_back #(
   parameter int TOURNAMENT_SIZE = pts_pkg::TOURNAMENT_SIZE_DEF,
   parameter int POP_INDEX_BITS  = pts_pkg::POP_INDEX_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [TOURNAMENT_SIZE*(POP_INDEX_BITS + pts_pkg::ENERGY_W
                 + $clog2(TOURNAMENT_SIZE)) + $clog2(TOURNAMENT_SIZE) - 1:0] in_data,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((POP_INDEX_BITS + pts_pkg::ENERGY_W + $clog2(TOURNAMENT_SIZE) + 7) / 8)
                 * 8 - 1:0] rsp_tdata
);
   import pts_pkg::*;

   localparam int N        = TOURNAMENT_SIZE;
   localparam int PB       = POP_INDEX_BITS;
   localparam int RW       = $clog2(N);
   localparam int ENG_OFF  = N * PB;
   localparam int RANK_OFF = N * (PB + ENERGY_W);
   localparam int WIN_OFF  = RANK_OFF + N * RW;
   localparam int RSP_W    = ((PB + ENERGY_W + RW + 7) / 8) * 8;

   logic [RW-1:0]       win_rank;
   logic [PB-1:0]       sel_index;
   logic [ENERGY_W-1:0] sel_energy;
   logic                valid_ff, valid_in;
   logic [RSP_W-1:0]    data_ff, data_in;

   assign win_rank = in_data[WIN_OFF +: RW];

   always_comb begin
      sel_index  = '0;
      sel_energy = '0;
      for (int i = 0; i < N; i++) begin
         if (in_data[RANK_OFF + i*RW +: RW] == win_rank) begin
            sel_index  = in_data[i*PB +: PB];
            sel_energy = in_data[ENG_OFF + i*ENERGY_W +: ENERGY_W];
         end
      end
   end

   assign in_ready = !valid_ff || rsp_tready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = RSP_W'({win_rank, sel_energy, sel_index});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

@@ src/pts_checker.sv @@
// ----------------------------------------------------------------------------
// pts_port_props
// port-level checks for the tournament selector, bound to the top level
// ----------------------------------------------------------------------------
module pts_port_props #(
   parameter int TOURNAMENT_SIZE = pts_pkg::TOURNAMENT_SIZE_DEF,
   parameter int POP_INDEX_BITS  = pts_pkg::POP_INDEX_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((POP_INDEX_BITS + pts_pkg::ENERGY_W + $clog2(TOURNAMENT_SIZE) + 7) / 8)
                * 8 - 1:0] rsp_tdata,
   input logic csr_wr_en
);

   // thresholds are stale right after a rate write
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("request taken right after rate write");

   // an idle response side wakes up only behind an accepted request that has passed the queue and response register
   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without matching request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind probabilistic_tournament_select pts_port_props #(
   .TOURNAMENT_SIZE(TOURNAMENT_SIZE),
   .POP_INDEX_BITS (POP_INDEX_BITS)
) u_pts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .csr_wr_en (csr_wr_en)
);
